@@ design/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page cache tag store package
// Shared widths, codes and control structures of the tag store and its cells.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Broadcast to every cell during the commit cycle.
  typedef struct packed {
    logic en;
    logic hit_en;
    logic drop_en;
  } cell_cmd_t;

  // Per-cell selects of the commit cycle.
  typedef struct packed {
    logic wr;
    logic hit;
    logic drop;
  } cell_sel_t;

endpackage

@@ design/lpc_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one lookup, insert or remove request.
// ----------------------------------------------------------------------------
interface lpc_req_if;

  logic                          valid;
  logic                          ready;
  logic [lpc_pkg::MODE_W-1:0]    mode;
  logic [lpc_pkg::PAGE_W-1:0]    page_number;
  logic [lpc_pkg::OWNER_W-1:0]   owner_tag;
  logic                          page_valid;
  logic [lpc_pkg::SLOT_W-1:0]    slot_index;

  modport source (
    output valid, mode, page_number, owner_tag, page_valid, slot_index,
    input  ready
  );

  modport sink (
    input  valid, mode, page_number, owner_tag, page_valid, slot_index,
    output ready
  );

endinterface

@@ design/lpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface lpc_rsp_if;

  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lpc_pkg::SLOT_W-1:0]    result_slot;
  logic                          evicted;
  logic [lpc_pkg::PAGE_W-1:0]    evicted_page;
  logic [lpc_pkg::OWNER_W-1:0]   evicted_owner;
  logic                          writeback_needed;
  logic                          error;

  modport source (
    output valid, hit, result_slot, evicted, evicted_page, evicted_owner,
           writeback_needed, error,
    input  ready
  );

  modport sink (
    input  valid, hit, result_slot, evicted, evicted_page, evicted_owner,
           writeback_needed, error,
    output ready
  );

endinterface

@@ design/lpc_cell.sv @@
// ----------------------------------------------------------------------------
// Tag store cell
// One entry of the tag store with its recency and insertion ranks; links to
// its neighbors through the free-slot chain.
// ----------------------------------------------------------------------------
module lpc_cell #(
  parameter int unsigned RANK_W = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpc_pkg::cell_cmd_t            cmd_i,
  input  lpc_pkg::cell_sel_t            sel_i,
  input  logic [lpc_pkg::PAGE_W-1:0]    page_i,
  input  logic [lpc_pkg::OWNER_W-1:0]   owner_i,
  input  logic                          pvalid_i,
  input  logic [RANK_W-1:0]             hit_use_i,
  input  logic [RANK_W-1:0]             mru_rank_i,
  input  logic [RANK_W-1:0]             new_rank_i,
  input  logic [RANK_W-1:0]             drop_use_i,
  input  logic [RANK_W-1:0]             drop_ins_i,
  input  logic                          evict_i,
  input  logic                          free_below_i,
  output logic                          free_below_o,
  output logic                          first_free_o,
  output logic                          occ_o,
  output logic                          match_o,
  output logic                          victim_o,
  output logic [RANK_W-1:0]             use_rank_o,
  output logic [RANK_W-1:0]             ins_rank_o,
  output logic [lpc_pkg::PAGE_W-1:0]    page_o,
  output logic [lpc_pkg::OWNER_W-1:0]   owner_o,
  output logic                          vmark_o
);

  logic                          occ_q;
  logic [lpc_pkg::PAGE_W-1:0]    page_q;
  logic [lpc_pkg::OWNER_W-1:0]   owner_q;
  logic                          vmark_q;
  logic [RANK_W-1:0]             use_q, use_d;
  logic [RANK_W-1:0]             ins_q, ins_d;
  logic                          victim;
  logic                          free_here;

  always_comb begin
    victim       = occ_q && (use_q == '0);
    free_here    = !occ_q || (evict_i && victim);
    first_free_o = free_here && !free_below_i;
    free_below_o = free_below_i || free_here;
    match_o      = occ_q && vmark_q && (page_q == page_i) && (owner_q == owner_i);
    victim_o     = victim;
    occ_o        = occ_q;
    use_rank_o   = use_q;
    ins_rank_o   = ins_q;
    page_o       = page_q;
    owner_o      = owner_q;
    vmark_o      = vmark_q;
  end

  // Ranks above a dropped or promoted entry move down to close the gap.
  always_comb begin
    use_d = use_q;
    ins_d = ins_q;
    if (sel_i.wr) begin
      use_d = new_rank_i;
      ins_d = new_rank_i;
    end else if (sel_i.hit) begin
      use_d = mru_rank_i;
    end else if (occ_q && !sel_i.drop) begin
      if (cmd_i.hit_en && (use_q > hit_use_i)) begin
        use_d = use_q - 1'b1;
      end
      if (cmd_i.drop_en && (use_q > drop_use_i)) begin
        use_d = use_q - 1'b1;
      end
      if (cmd_i.drop_en && (ins_q > drop_ins_i)) begin
        ins_d = ins_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (cmd_i.en) begin
      if (sel_i.wr) begin
        occ_q <= 1'b1;
      end else if (sel_i.drop) begin
        occ_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      use_q <= use_d;
      ins_q <= ins_d;
      if (sel_i.wr) begin
        page_q  <= page_i;
        owner_q <= owner_i;
        vmark_q <= pvalid_i;
      end
    end
  end

endmodule

@@ design/lru_page_cache_tag_store.sv @@
// ----------------------------------------------------------------------------
// LRU page cache tag store
// Fully associative tag store with least-recently-used replacement, built
// as a row of entry cells and a scan/commit controller.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake      | Contents
// req_i   | in        | valid/ready    | mode, page, owner, valid mark, slot
// rsp_o   | out       | valid/ready    | hit, slot, evicted entry, error
// cfg     | in        | cfg_we_i only  | capacity register
//
// Each request passes through a scan cycle, where every cell compares its
// entry and the selects are registered, and a commit cycle, where the cells
// update their ranks and the result is loaded into the output register.
// The next request is accepted in the commit cycle, while the current one
// completes. The commit waits while the output register holds an unread
// result not being taken. Reset empties the store and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_page_cache_tag_store #(
  parameter int unsigned ENTRIES = lpc_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lpc_req_if.sink                       req_i,
  lpc_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [lpc_pkg::CAP_W-1:0]     cfg_wdata_i
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (FW > lpc_pkg::CAP_W) ? FW : lpc_pkg::CAP_W;

  lpc_pkg::state_e state_q, state_d;

  logic [lpc_pkg::CAP_W-1:0]     cap_q;
  logic [FW-1:0]                 fill_q;

  logic [lpc_pkg::MODE_W-1:0]    req_mode_q;
  logic [lpc_pkg::PAGE_W-1:0]    req_page_q;
  logic [lpc_pkg::OWNER_W-1:0]   req_owner_q;
  logic                          req_pvalid_q;
  logic [lpc_pkg::SLOT_W-1:0]    req_slot_q;

  logic                          accept;
  logic                          commit_en;

  // Cell row.
  logic [ENTRIES:0]              free_chain;
  logic [ENTRIES-1:0]            first_free_vec;
  logic [ENTRIES-1:0]            occ_vec;
  logic [ENTRIES-1:0]            match_vec;
  logic [ENTRIES-1:0]            victim_vec;
  logic [RW-1:0]                 cell_use  [ENTRIES];
  logic [RW-1:0]                 cell_ins  [ENTRIES];
  logic [lpc_pkg::PAGE_W-1:0]    cell_page [ENTRIES];
  logic [lpc_pkg::OWNER_W-1:0]   cell_owner[ENTRIES];
  logic [ENTRIES-1:0]            cell_vmark;
  lpc_pkg::cell_sel_t            cell_sel  [ENTRIES];
  lpc_pkg::cell_cmd_t            cell_cmd;

  // Scan results.
  logic                          is_lookup, is_insert, is_remove;
  logic [CW-1:0]                 cap_eff;
  logic                          evict_scan;
  logic [ENTRIES-1:0]            rank_vec;
  logic                          found_d;
  logic [RW-1:0]                 best_d;
  logic [ENTRIES-1:0]            drop_vec_d;
  logic [RW-1:0]                 drop_use_d, drop_ins_d;
  logic [lpc_pkg::PAGE_W-1:0]    drop_page_d;
  logic [lpc_pkg::OWNER_W-1:0]   drop_owner_d;
  logic                          drop_vmark_d;
  logic [RW-1:0]                 write_idx_d;

  logic [ENTRIES-1:0]            match_q;
  logic                          found_q;
  logic [RW-1:0]                 best_q;
  logic [ENTRIES-1:0]            drop_vec_q;
  logic                          drop_any_q;
  logic [RW-1:0]                 drop_use_q, drop_ins_q;
  logic [lpc_pkg::PAGE_W-1:0]    drop_page_q;
  logic [lpc_pkg::OWNER_W-1:0]   drop_owner_q;
  logic                          drop_vmark_q;
  logic [ENTRIES-1:0]            write_vec_q;
  logic [RW-1:0]                 write_idx_q;

  // Commit values.
  logic [ENTRIES-1:0]            hit_vec;
  logic [RW-1:0]                 hit_idx;
  logic [RW-1:0]                 hit_use;
  logic [RW-1:0]                 mru_rank;
  logic [RW-1:0]                 new_rank;
  logic [FW-1:0]                 fill_after_drop;
  logic [FW-1:0]                 fill_d;

  // Output register.
  logic                          rsp_valid_q;
  logic                          rsp_hit_q;
  logic [lpc_pkg::SLOT_W-1:0]    rsp_slot_q;
  logic                          rsp_evicted_q;
  logic [lpc_pkg::PAGE_W-1:0]    rsp_page_q;
  logic [lpc_pkg::OWNER_W-1:0]   rsp_owner_q;
  logic                          rsp_wb_q;
  logic                          rsp_error_q;

  assign is_lookup = (req_mode_q == lpc_pkg::MODE_LOOKUP);
  assign is_insert = (req_mode_q == lpc_pkg::MODE_INSERT);
  assign is_remove = (req_mode_q == lpc_pkg::MODE_REMOVE);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    commit_en    = 1'b0;
    req_i.ready  = 1'b0;
    unique case (state_q)
      lpc_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = lpc_pkg::ST_SCAN;
        end
      end
      lpc_pkg::ST_SCAN: begin
        state_d = lpc_pkg::ST_COMMIT;
      end
      lpc_pkg::ST_COMMIT: begin
        commit_en   = !rsp_valid_q || rsp_o.ready;
        req_i.ready = commit_en;
        if (commit_en) begin
          state_d = req_i.valid ? lpc_pkg::ST_SCAN : lpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpc_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q   <= req_i.mode;
      req_page_q   <= req_i.page_number;
      req_owner_q  <= req_i.owner_tag;
      req_pvalid_q <= req_i.page_valid;
      req_slot_q   <= req_i.slot_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= lpc_pkg::CAPACITY_RESET;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit_en) begin
        fill_q <= fill_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  assign free_chain[0] = 1'b0;

  assign cell_cmd.en      = commit_en;
  assign cell_cmd.hit_en  = is_lookup && found_q;
  assign cell_cmd.drop_en = drop_any_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign cell_sel[g].wr   = is_insert && write_vec_q[g];
    assign cell_sel[g].hit  = hit_vec[g];
    assign cell_sel[g].drop = drop_vec_q[g];

    lpc_cell #(
      .RANK_W (RW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cell_cmd),
      .sel_i        (cell_sel[g]),
      .page_i       (req_page_q),
      .owner_i      (req_owner_q),
      .pvalid_i     (req_pvalid_q),
      .hit_use_i    (hit_use),
      .mru_rank_i   (mru_rank),
      .new_rank_i   (new_rank),
      .drop_use_i   (drop_use_q),
      .drop_ins_i   (drop_ins_q),
      .evict_i      (evict_scan),
      .free_below_i (free_chain[g]),
      .free_below_o (free_chain[g+1]),
      .first_free_o (first_free_vec[g]),
      .occ_o        (occ_vec[g]),
      .match_o      (match_vec[g]),
      .victim_o     (victim_vec[g]),
      .use_rank_o   (cell_use[g]),
      .ins_rank_o   (cell_ins[g]),
      .page_o       (cell_page[g]),
      .owner_o      (cell_owner[g]),
      .vmark_o      (cell_vmark[g])
    );
  end

  // --------------------------------------------------------------------------
  // Scan cycle
  // --------------------------------------------------------------------------
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(cap_q) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_q);
    end
    evict_scan = is_insert && (CW'(fill_q) >= cap_eff);
  end

  // The newest matching entry is found through a map of insert ranks, one bit per rank.
  always_comb begin
    rank_vec = '0;
    best_d   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (is_lookup && match_vec[i]) begin
        rank_vec[cell_ins[i]] = 1'b1;
      end
    end
    for (int r = 0; r < ENTRIES; r++) begin
      if (rank_vec[r]) begin
        best_d = RW'(r);
      end
    end
    found_d = |rank_vec;
  end

  always_comb begin
    drop_vec_d   = '0;
    drop_use_d   = '0;
    drop_ins_d   = '0;
    drop_page_d  = '0;
    drop_owner_d = '0;
    drop_vmark_d = 1'b0;
    write_idx_d  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (evict_scan) begin
        drop_vec_d[i] = victim_vec[i];
      end else if (is_remove) begin
        drop_vec_d[i] = occ_vec[i] && (int'(req_slot_q) == i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (drop_vec_d[i]) begin
        drop_use_d   = drop_use_d | cell_use[i];
        drop_ins_d   = drop_ins_d | cell_ins[i];
        drop_page_d  = drop_page_d | cell_page[i];
        drop_owner_d = drop_owner_d | cell_owner[i];
        drop_vmark_d = drop_vmark_d | cell_vmark[i];
      end
      if (first_free_vec[i]) begin
        write_idx_d = write_idx_d | RW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpc_pkg::ST_SCAN) begin
      match_q      <= match_vec;
      found_q      <= found_d;
      best_q       <= best_d;
      drop_vec_q   <= drop_vec_d;
      drop_any_q   <= |drop_vec_d;
      drop_use_q   <= drop_use_d;
      drop_ins_q   <= drop_ins_d;
      drop_page_q  <= drop_page_d;
      drop_owner_q <= drop_owner_d;
      drop_vmark_q <= drop_vmark_d;
      write_vec_q  <= first_free_vec;
      write_idx_q  <= write_idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Commit cycle
  // --------------------------------------------------------------------------
  always_comb begin
    hit_idx = '0;
    hit_use = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = is_lookup && found_q && match_q[i] && (cell_ins[i] == best_q);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | RW'(i);
        hit_use = hit_use | cell_use[i];
      end
    end
    fill_after_drop = fill_q - {{(FW-1){1'b0}}, drop_any_q};
    mru_rank        = RW'(fill_q - 1'b1);
    new_rank        = RW'(fill_after_drop);
    unique case (req_mode_q)
      lpc_pkg::MODE_INSERT: fill_d = fill_after_drop + 1'b1;
      lpc_pkg::MODE_REMOVE: fill_d = fill_after_drop;
      default:              fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit_en) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_en) begin
      rsp_hit_q     <= cell_cmd.hit_en;
      rsp_evicted_q <= drop_any_q;
      rsp_page_q    <= drop_page_q;
      rsp_owner_q   <= drop_owner_q;
      rsp_wb_q      <= drop_vmark_q;
      rsp_error_q   <= is_remove && !drop_any_q;
      unique case (req_mode_q)
        lpc_pkg::MODE_LOOKUP: rsp_slot_q <= lpc_pkg::SLOT_W'(hit_idx);
        lpc_pkg::MODE_INSERT: rsp_slot_q <= lpc_pkg::SLOT_W'(write_idx_q);
        default:              rsp_slot_q <= '0;
      endcase
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.hit              = rsp_hit_q;
  assign rsp_o.result_slot      = rsp_slot_q;
  assign rsp_o.evicted          = rsp_evicted_q;
  assign rsp_o.evicted_page     = rsp_page_q;
  assign rsp_o.evicted_owner    = rsp_owner_q;
  assign rsp_o.writeback_needed = rsp_wb_q;
  assign rsp_o.error            = rsp_error_q;

`ifndef ASSERT_OFF
  a_fill_matches_cells: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(fill_q)
  ) else $error("Fill count differs from the number of occupied cells.");

  a_single_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpc_pkg::ST_COMMIT) |-> $onehot0(hit_vec)
  ) else $error("More than one cell selected as the lookup hit.");

  a_single_drop: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpc_pkg::ST_COMMIT) |-> $onehot0(drop_vec_q)
  ) else $error("More than one cell selected for dropping.");

  a_insert_has_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpc_pkg::ST_COMMIT && req_mode_q == lpc_pkg::MODE_INSERT)
      |-> $onehot(write_vec_q)
  ) else $error("Insert commits without exactly one free slot.");

  a_no_accept_in_scan: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpc_pkg::ST_SCAN) |-> !req_i.ready
  ) else $error("Request accepted during the scan cycle.");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page cache tag store testbench
// Drives lookup, insert and remove requests through the valid/ready request
// channel, predicts every response from a private copy of the tag store,
// and compares the responses field by field. The capacity register is
// rewritten between phases while the store is idle, and both channels stall
// at random, with a long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam time         CLK_PERIOD    = 12ns;
  localparam int unsigned SLOTS         = lpc_pkg::ENTRIES_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_OFF_LEN  = 300;

  localparam logic [lpc_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [lpc_pkg::MODE_W-1:0]  mode;
    logic [lpc_pkg::PAGE_W-1:0]  page;
    logic [lpc_pkg::OWNER_W-1:0] owner;
    logic                        pvalid;
    logic [lpc_pkg::SLOT_W-1:0]  slot;
  } tag_req_t;

  typedef struct packed {
    logic                        hit;
    logic [lpc_pkg::SLOT_W-1:0]  result_slot;
    logic                        evicted;
    logic [lpc_pkg::PAGE_W-1:0]  evicted_page;
    logic [lpc_pkg::OWNER_W-1:0] evicted_owner;
    logic                        writeback_needed;
    logic                        error;
  } tag_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [lpc_pkg::CAP_W-1:0]    cfg_wdata_i;

  lpc_req_if req_if ();
  lpc_rsp_if rsp_if ();

  lru_page_cache_tag_store u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Private copy of the tag store.
  logic                         slot_busy  [SLOTS];
  logic [lpc_pkg::PAGE_W-1:0]   slot_page  [SLOTS];
  logic [lpc_pkg::OWNER_W-1:0]  slot_owner [SLOTS];
  logic                         slot_vmark [SLOTS];
  logic [lpc_pkg::SLOT_W-1:0]   recency    [SLOTS];
  logic [lpc_pkg::SLOT_W-1:0]   age_order  [SLOTS];
  logic [lpc_pkg::CAP_W-1:0]    busy_count;
  logic [lpc_pkg::CAP_W-1:0]    cap_reg;

  tag_req_t            queued_requests_q[$];
  tag_result_t         pending_outcomes_q[$];

  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         hold_off_cycles;
  int unsigned         stall_cycles;
  int unsigned         mismatches;

  function automatic void release_slot(int unsigned s, ref tag_result_t res);
    res.evicted          = 1'b1;
    res.evicted_page     = slot_page[s];
    res.evicted_owner    = slot_owner[s];
    res.writeback_needed = slot_vmark[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i] && i != s) begin
        if (recency[i] > recency[s]) recency[i]--;
        if (age_order[i] > age_order[s]) age_order[i]--;
      end
    end
    slot_busy[s] = 1'b0;
    if (busy_count != 0) busy_count--;
  endfunction

  function automatic tag_result_t compute_tag_outcome(tag_req_t r);
    tag_result_t res;
    logic        found;
    int unsigned best;
    int unsigned eff_cap;
    int unsigned free_idx;
    res   = '0;
    found = 1'b0;
    best  = 0;
    case (r.mode)
      lpc_pkg::MODE_LOOKUP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_vmark[i] && slot_page[i] == r.page &&
              slot_owner[i] == r.owner && (!found || age_order[i] > age_order[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && recency[i] > recency[best]) recency[i]--;
          end
          recency[best]   = lpc_pkg::SLOT_W'(busy_count - 1'b1);
          res.hit         = 1'b1;
          res.result_slot = lpc_pkg::SLOT_W'(best);
        end
      end
      lpc_pkg::MODE_INSERT: begin
        eff_cap = cap_reg;
        if (eff_cap == 0) eff_cap = 1;
        if (eff_cap > SLOTS) eff_cap = SLOTS;
        if (busy_count >= eff_cap) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && (!found || recency[i] < recency[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) release_slot(best, res);
        end
        free_idx = 0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_idx = i;
        end
        slot_busy[free_idx]  = 1'b1;
        slot_page[free_idx]  = r.page;
        slot_owner[free_idx] = r.owner;
        slot_vmark[free_idx] = r.pvalid;
        recency[free_idx]    = lpc_pkg::SLOT_W'(busy_count);
        age_order[free_idx]  = lpc_pkg::SLOT_W'(busy_count);
        busy_count++;
        res.result_slot = lpc_pkg::SLOT_W'(free_idx);
      end
      lpc_pkg::MODE_REMOVE: begin
        if (slot_busy[r.slot]) begin
          release_slot(r.slot, res);
        end else begin
          res.error = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_request(logic [lpc_pkg::MODE_W-1:0] mode,
                               logic [lpc_pkg::PAGE_W-1:0] page,
                               logic [lpc_pkg::OWNER_W-1:0] owner, logic pvalid,
                               logic [lpc_pkg::SLOT_W-1:0] slot);
    tag_req_t r;
    r = '{mode: mode, page: page, owner: owner, pvalid: pvalid, slot: slot};
    queued_requests_q.push_back(r);
  endtask

  task automatic settle();
    while (queued_requests_q.size() != 0 || pending_outcomes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lpc_pkg::CAP_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg      = value;
  endtask

  task automatic queue_random_batch(int unsigned count);
    logic [lpc_pkg::PAGE_W-1:0]  pages[6];
    logic [lpc_pkg::OWNER_W-1:0] owners[3];
    tag_req_t                    r;
    int unsigned                 pick;
    pages[0]  = '0;
    pages[1]  = '1;
    for (int k = 2; k < 6; k++) pages[k] = $urandom;
    owners[0] = '0;
    owners[1] = '1;
    owners[2] = lpc_pkg::OWNER_W'($urandom);
    repeat (count) begin
      pick     = $urandom_range(99);
      r.page   = ($urandom_range(9) == 0) ? $urandom : pages[$urandom_range(5)];
      r.owner  = ($urandom_range(19) == 0) ? lpc_pkg::OWNER_W'($urandom)
                                           : owners[$urandom_range(2)];
      r.pvalid = 1'($urandom_range(1));
      r.slot   = lpc_pkg::SLOT_W'($urandom_range(SLOTS - 1));
      if (pick < 45) begin
        r.mode = lpc_pkg::MODE_INSERT;
      end else if (pick < 82) begin
        r.mode = lpc_pkg::MODE_LOOKUP;
      end else if (pick < 97) begin
        r.mode = lpc_pkg::MODE_REMOVE;
      end else begin
        r.mode = MODE_RESERVED;
      end
      queued_requests_q.push_back(r);
    end
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin : drive_requests
    tag_req_t head;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        pending_outcomes_q.push_back(compute_tag_outcome(queued_requests_q.pop_front()));
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          head               = queued_requests_q[0];
          req_if.valid       <= 1'b1;
          req_if.mode        <= head.mode;
          req_if.page_number <= head.page;
          req_if.owner_tag   <= head.owner;
          req_if.page_valid  <= head.pvalid;
          req_if.slot_index  <= head.slot;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    tag_result_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_outcomes_q.size() == 0) begin
          $error("Response received with no request outstanding.");
          mismatches++;
        end else begin
          want = pending_outcomes_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
          check_field("result_slot", 32'(want.result_slot), 32'(rsp_if.result_slot));
          check_field("evicted", 32'(want.evicted), 32'(rsp_if.evicted));
          check_field("evicted_page", want.evicted_page, rsp_if.evicted_page);
          check_field("evicted_owner", 32'(want.evicted_owner),
                      32'(rsp_if.evicted_owner));
          check_field("writeback_needed", 32'(want.writeback_needed),
                      32'(rsp_if.writeback_needed));
          check_field("error", 32'(want.error), 32'(rsp_if.error));
        end
      end
      if (hold_off_cycles != 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        rsp_if.ready    <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lru_page_cache_tag_store regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.mode        = lpc_pkg::MODE_LOOKUP;
    req_if.page_number = '0;
    req_if.owner_tag   = '0;
    req_if.page_valid  = 1'b0;
    req_if.slot_index  = '0;
    rsp_if.ready       = 1'b0;
    stall_cycles       = 0;
    mismatches         = 0;
    hold_off_cycles    = 0;
    send_idle_pct      = 12;
    recv_idle_pct      = 78;
    cap_reg            = lpc_pkg::CAPACITY_RESET;
    busy_count         = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_request(lpc_pkg::MODE_LOOKUP, '0, '0, 1'b0, '0);
    queue_request(lpc_pkg::MODE_INSERT, '1, '1, 1'b1, '0);
    queue_request(lpc_pkg::MODE_INSERT, '0, '0, 1'b0, '1);
    queue_request(lpc_pkg::MODE_LOOKUP, '1, '1, 1'b1, '1);
    queue_request(lpc_pkg::MODE_LOOKUP, '0, '0, 1'b1, '0);
    queue_request(lpc_pkg::MODE_INSERT, '1, '1, 1'b1, '0);
    queue_request(lpc_pkg::MODE_LOOKUP, '1, '1, 1'b0, '0);
    queue_request(lpc_pkg::MODE_REMOVE, '0, '0, 1'b0, 4'd15);
    queue_request(lpc_pkg::MODE_REMOVE, '1, '1, 1'b1, 4'd1);
    queue_request(lpc_pkg::MODE_INSERT, 32'h0000_5a5a, 16'h1234, 1'b1, '0);
    queue_request(MODE_RESERVED, '1, '1, 1'b1, '1);
    queue_request(lpc_pkg::MODE_REMOVE, '0, '0, 1'b0, 4'd2);
    queue_request(lpc_pkg::MODE_LOOKUP, '1, '1, 1'b0, '0);

    write_capacity(5'd1);
    queue_request(lpc_pkg::MODE_INSERT, 32'h8000_0001, 16'h8001, 1'b1, '0);
    queue_request(lpc_pkg::MODE_INSERT, 32'h7fff_fffe, 16'h7ffe, 1'b0, '0);
    queue_request(lpc_pkg::MODE_LOOKUP, 32'h8000_0001, 16'h8001, 1'b0, '0);

    write_capacity(5'd0);
    queue_request(lpc_pkg::MODE_INSERT, 32'h1357_9bdf, 16'h2468, 1'b1, '0);
    queue_request(lpc_pkg::MODE_INSERT, 32'h1357_9bdf, 16'h2468, 1'b1, '0);
    queue_request(lpc_pkg::MODE_LOOKUP, 32'h1357_9bdf, 16'h2468, 1'b1, '0);
    queue_request(lpc_pkg::MODE_REMOVE, '0, '0, 1'b0, 4'd0);

    write_capacity(5'd31);
    hold_off_cycles = HOLD_OFF_LEN;
    queue_random_batch(90);
    write_capacity(5'd5);
    queue_random_batch(80);

    settle();
    send_idle_pct = 78;
    recv_idle_pct = 12;
    write_capacity(5'd16);
    queue_random_batch(90);
    write_capacity(5'd2);
    queue_random_batch(80);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(5'd9);
    queue_random_batch(90);
    write_capacity(5'd16);
    queue_random_batch(80);

    settle();
    if (pending_outcomes_q.size() != 0) begin
      $error("%0d responses never arrived.", pending_outcomes_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("lru_page_cache_tag_store regression: pass");
    end else begin
      $display("lru_page_cache_tag_store regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lpc_pkg.sv
design/lpc_req_if.sv
design/lpc_rsp_if.sv
design/lpc_cell.sv
design/lru_page_cache_tag_store.sv
tb/tb_top.sv
